// ===== hdl/error_diffusion_dither_core_defines.svh =====
// assertion macros for the error diffusion dither core
`ifndef ERROR_DIFFUSION_DITHER_CORE_DEFINES_SVH
`define ERROR_DIFFUSION_DITHER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define EDD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("edd assertion failed");
`define EDD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("edd assertion failed");
`else
`define EDD_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define EDD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== hdl/edd_pkg.sv =====
// shared constants, payload types and command codes of the dither core
package edd_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int ROW_AW    = $clog2(MAX_WIDTH);
  localparam int PTR_W     = ROW_AW + 1;
  localparam int PAL_SIZE  = 256;
  localparam int PAL_AW    = $clog2(PAL_SIZE);

  localparam logic [1:0] KIND_PIXEL     = 2'd0;
  localparam logic [1:0] KIND_PAL_WR    = 2'd1;
  localparam logic [1:0] KIND_ROW_END   = 2'd2;
  localparam logic [1:0] KIND_IMG_BEGIN = 2'd3;

  localparam logic [7:0] SAT_MAX   = 8'hFF;
  localparam logic [7:0] MASK_GRAY = 8'hE0;
  localparam logic [7:0] MASK_BW   = 8'h80;

  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE   = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD   = 4'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 4'd2;
  localparam logic [OP_W-1:0] OP_SWAP   = 4'd3;
  localparam logic [OP_W-1:0] OP_PALW   = 4'd4;
  localparam logic [OP_W-1:0] OP_PX0    = 4'd5;
  localparam logic [OP_W-1:0] OP_PX1    = 4'd6;
  localparam logic [OP_W-1:0] OP_PX2    = 4'd7;
  localparam logic [OP_W-1:0] OP_PX3    = 4'd8;
  localparam logic [OP_W-1:0] OP_PX4    = 4'd9;
  localparam logic [OP_W-1:0] OP_RESULT = 4'd10;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  value;
    logic [7:0]  palette_slot;
    logic [9:0]  column;
    logic [10:0] row_width;
    logic        use_palette;
  } item_t;

  typedef struct packed {
    logic [2:0] level;
    logic [9:0] out_column;
  } result_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic swap_done;
    logic res_free;
  } sts_t;

endpackage

// ===== hdl/error_diffusion_dither_core.sv =====
// error diffusion dither core: top level with controller and datapath
// pixel: the input transfer leads through PX0 to PX4 to the result state, which waits
// for a free result register, and no new item is taken meanwhile; end of row moves
// min(row_width, 1024) next-row error entries into the current row and clears them
// begin image and reset clear both error rows, one error entry of each row per cycle,
// with no input taken; the config channel is always ready, the palette never cleared
`include "error_diffusion_dither_core_defines.svh"

module error_diffusion_dither_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  edd_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output edd_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_data
);

  edd_pkg::cmd_t cmd;
  edd_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  edd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_kind  (item.kind),
    .item_ready (item_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  edd_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item_in      (item),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .sts          (sts),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  `EDD_ASSERT_NEXT(a_busy_after_transfer, clk, rst, item_valid && item_ready, !item_ready)
  `EDD_ASSERT_IMPLY(a_result_slot_free, clk, rst, cmd.op == edd_pkg::OP_RESULT, sts.res_free)
  `EDD_ASSERT_IMPLY(a_clear_after_reset, clk, rst, $past(rst), !item_ready)

endmodule

// ===== hdl/edd_ctrl.sv =====
// sequencer for pixel, palette, row swap and clear operations
module edd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic [1:0]       item_kind,
  output logic             item_ready,
  input  edd_pkg::sts_t    sts,
  output edd_pkg::cmd_t    cmd
);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_PALW  = 4'd2;
  localparam logic [3:0] ST_SWAP  = 4'd3;
  localparam logic [3:0] ST_PX0   = 4'd4;
  localparam logic [3:0] ST_PX1   = 4'd5;
  localparam logic [3:0] ST_PX2   = 4'd6;
  localparam logic [3:0] ST_PX3   = 4'd7;
  localparam logic [3:0] ST_PX4   = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  assign item_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = edd_pkg::OP_NONE;
    case (state)
      ST_CLEAR: begin
        if (sts.clear_done) begin
          state_next = ST_IDLE;
        end else begin
          cmd.op = edd_pkg::OP_CLEAR;
        end
      end
      ST_IDLE: begin
        if (item_valid) begin
          cmd.op = edd_pkg::OP_LOAD;
          case (item_kind)
            edd_pkg::KIND_PIXEL:   state_next = ST_PX0;
            edd_pkg::KIND_PAL_WR:  state_next = ST_PALW;
            edd_pkg::KIND_ROW_END: state_next = ST_SWAP;
            default:               state_next = ST_CLEAR;
          endcase
        end
      end
      ST_PALW: begin
        cmd.op     = edd_pkg::OP_PALW;
        state_next = ST_IDLE;
      end
      ST_SWAP: begin
        if (sts.swap_done) begin
          state_next = ST_IDLE;
        end else begin
          cmd.op = edd_pkg::OP_SWAP;
        end
      end
      ST_PX0: begin
        cmd.op     = edd_pkg::OP_PX0;
        state_next = ST_PX1;
      end
      ST_PX1: begin
        cmd.op     = edd_pkg::OP_PX1;
        state_next = ST_PX2;
      end
      ST_PX2: begin
        cmd.op     = edd_pkg::OP_PX2;
        state_next = ST_PX3;
      end
      ST_PX3: begin
        cmd.op     = edd_pkg::OP_PX3;
        state_next = ST_PX4;
      end
      ST_PX4: begin
        cmd.op     = edd_pkg::OP_PX4;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (sts.res_free) begin
          cmd.op     = edd_pkg::OP_RESULT;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hdl/edd_datapath.sv =====
// row error stores, palette, quantizer and result register
module edd_datapath (
  input  logic             clk,
  input  logic             rst,
  input  edd_pkg::item_t   item_in,
  input  logic             cfg_valid,
  input  logic             cfg_data,
  input  edd_pkg::cmd_t    cmd,
  output edd_pkg::sts_t    sts,
  output logic             result_valid,
  input  logic             result_ready,
  output edd_pkg::result_t result
);

  edd_pkg::item_t item;
  logic           bw;

  logic [7:0] cur_mem [edd_pkg::MAX_WIDTH];
  logic [7:0] nxt_mem [edd_pkg::MAX_WIDTH];
  logic [7:0] pal_mem [edd_pkg::PAL_SIZE];
  logic [7:0] cur_rd;
  logic [7:0] nxt_rd;
  logic [7:0] pal_rd;

  logic [edd_pkg::PTR_W-1:0]  ptr;
  logic                       pend;
  logic [edd_pkg::ROW_AW-1:0] pend_addr;
  logic [7:0]                 q;
  logic [2:0]                 level;

  logic [edd_pkg::ROW_AW-1:0] col;
  logic [edd_pkg::ROW_AW-1:0] col_p1;
  logic [edd_pkg::ROW_AW-1:0] col_m1;
  logic                       right_ok;
  logic                       left_ok;
  logic [edd_pkg::PTR_W-1:0]  row_n;
  logic                       swap_rd_ok;

  logic [7:0] px_raw;
  logic [7:0] px;
  logic [8:0] sum;
  logic [7:0] oldp;
  logic [7:0] mask;
  logic [7:0] newp;
  logic [7:0] qv;

  logic [10:0] q7;
  logic [10:0] q5;
  logic [10:0] q3;
  logic [7:0]  err7;
  logic [7:0]  err5;
  logic [7:0]  err3;
  logic [7:0]  err1;

  logic [edd_pkg::ROW_AW-1:0] cur_ra;
  logic [edd_pkg::ROW_AW-1:0] cur_wa;
  logic [7:0]                 cur_wd;
  logic                       cur_we;
  logic [edd_pkg::ROW_AW-1:0] nxt_ra;
  logic [edd_pkg::ROW_AW-1:0] nxt_wa;
  logic [7:0]                 nxt_wd;
  logic                       nxt_we;

  assign col      = item.column;
  assign col_p1   = col + edd_pkg::ROW_AW'(1);
  assign col_m1   = col - edd_pkg::ROW_AW'(1);
  assign left_ok  = (col != '0);
  assign right_ok = ({1'b0, col} != edd_pkg::PTR_W'(edd_pkg::MAX_WIDTH - 1)) &&
                    (({1'b0, col} + edd_pkg::PTR_W'(1)) != item.row_width);

  assign row_n      = (item.row_width < edd_pkg::PTR_W'(edd_pkg::MAX_WIDTH)) ?
                      item.row_width : edd_pkg::PTR_W'(edd_pkg::MAX_WIDTH);
  assign swap_rd_ok = (ptr < row_n);

  // quantizer
  assign px_raw = item.use_palette ? pal_rd : item.value;
  assign px     = bw ? {1'b0, px_raw[7:1]} : px_raw;
  assign sum    = {1'b0, cur_rd} + {1'b0, px};
  assign oldp   = sum[8] ? edd_pkg::SAT_MAX : sum[7:0];
  assign mask   = bw ? edd_pkg::MASK_BW : edd_pkg::MASK_GRAY;
  assign newp   = oldp & mask;
  assign qv     = oldp & ~mask;

  // error shares
  assign q7   = {3'b000, q} * 11'd7;
  assign q5   = {3'b000, q} * 11'd5;
  assign q3   = {3'b000, q} * 11'd3;
  assign err7 = {1'b0, q7[10:4]};
  assign err5 = {1'b0, q5[10:4]};
  assign err3 = {1'b0, q3[10:4]};
  assign err1 = {4'h0, q[7:4]};

  always_comb begin
    cur_ra = col;
    cur_we = 1'b0;
    cur_wa = ptr[edd_pkg::ROW_AW-1:0];
    cur_wd = 8'h00;
    nxt_ra = col;
    nxt_we = 1'b0;
    nxt_wa = ptr[edd_pkg::ROW_AW-1:0];
    nxt_wd = 8'h00;
    case (cmd.op)
      edd_pkg::OP_CLEAR: begin
        cur_we = 1'b1;
        nxt_we = 1'b1;
      end
      edd_pkg::OP_SWAP: begin
        nxt_ra = ptr[edd_pkg::ROW_AW-1:0];
        cur_we = pend;
        cur_wa = pend_addr;
        cur_wd = nxt_rd;
        nxt_we = pend;
        nxt_wa = pend_addr;
      end
      edd_pkg::OP_PX0: begin
        cur_ra = col;
      end
      edd_pkg::OP_PX1: begin
        cur_ra = col_p1;
        nxt_ra = col_m1;
      end
      edd_pkg::OP_PX2: begin
        cur_we = right_ok;
        cur_wa = col_p1;
        cur_wd = cur_rd + err7;
        nxt_we = left_ok;
        nxt_wa = col_m1;
        nxt_wd = nxt_rd + err3;
        nxt_ra = col;
      end
      edd_pkg::OP_PX3: begin
        nxt_we = 1'b1;
        nxt_wa = col;
        nxt_wd = nxt_rd + err5;
        nxt_ra = col_p1;
      end
      edd_pkg::OP_PX4: begin
        nxt_we = right_ok;
        nxt_wa = col_p1;
        nxt_wd = nxt_rd + err1;
      end
      default: begin
        cur_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cur_we) begin
      cur_mem[cur_wa] <= cur_wd;
    end
    cur_rd <= cur_mem[cur_ra];
  end

  always_ff @(posedge clk) begin
    if (nxt_we) begin
      nxt_mem[nxt_wa] <= nxt_wd;
    end
    nxt_rd <= nxt_mem[nxt_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == edd_pkg::OP_PALW) begin
      pal_mem[item.palette_slot[edd_pkg::PAL_AW-1:0]] <= item.value;
    end
    pal_rd <= pal_mem[item.value[edd_pkg::PAL_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == edd_pkg::OP_LOAD) begin
      item <= item_in;
    end
    if (cmd.op == edd_pkg::OP_PX1) begin
      q     <= qv;
      level <= newp[7:5];
    end
    if (cmd.op == edd_pkg::OP_SWAP) begin
      pend_addr <= ptr[edd_pkg::ROW_AW-1:0];
    end
    if (cmd.op == edd_pkg::OP_RESULT) begin
      result.level      <= level;
      result.out_column <= item.column;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr          <= '0;
      pend         <= 1'b0;
      bw           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        bw <= cfg_data;
      end
      case (cmd.op)
        edd_pkg::OP_LOAD: begin
          ptr  <= '0;
          pend <= 1'b0;
        end
        edd_pkg::OP_CLEAR: begin
          ptr <= ptr + edd_pkg::PTR_W'(1);
        end
        edd_pkg::OP_SWAP: begin
          pend <= swap_rd_ok;
          if (swap_rd_ok) begin
            ptr <= ptr + edd_pkg::PTR_W'(1);
          end
        end
        default: begin
          pend <= pend;
        end
      endcase
      if (cmd.op == edd_pkg::OP_RESULT) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  assign sts.clear_done = (ptr == edd_pkg::PTR_W'(edd_pkg::MAX_WIDTH));
  assign sts.swap_done  = !swap_rd_ok && !pend;
  assign sts.res_free   = !result_valid || result_ready;

endmodule
